[rtl/core/prg_pkg.sv]
// ----------------------------------------------------------------------------
// prg_pkg
// Shared widths, register indexes, reset values and channel payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package prg_pkg;

  localparam int IDX_W      = 24;
  localparam int COORD_W    = 12;
  localparam int DIR_W      = 16;
  localparam int SIDE_REG_W = 13;
  localparam int SCALE_W    = 24;
  localparam int QUAT_W     = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_Z    = 3'd6;

  localparam logic [SIDE_REG_W-1:0]    RST_WIDTH  = 13'd640;
  localparam logic [SIDE_REG_W-1:0]    RST_HEIGHT = 13'd480;
  localparam logic [SCALE_W-1:0]       RST_SCALE  = 24'd26214;
  localparam logic signed [QUAT_W-1:0] RST_QW     = 16'sd32767;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
  } in_payload_t;

  typedef struct packed {
    logic [COORD_W-1:0]      pixel_col;
    logic [COORD_W-1:0]      pixel_row;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } out_payload_t;

endpackage

`default_nettype wire

[rtl/core/prg_stream_if.sv]
// ----------------------------------------------------------------------------
// prg_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface prg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/prg_div_pipe.sv]
// ----------------------------------------------------------------------------
// prg_div_pipe
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module prg_div_pipe #(
  parameter int NW = 24,
  parameter int DW = 13,
  parameter int QW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               out_valid,
  output logic [QW-1:0]      quo_o,
  output logic [NW-1:0]      rem_o
);

  localparam int WW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] n_r [QW];
  logic [DW-1:0] d_r [QW];
  logic [QW-1:0] q_r [QW];
  logic [QW-1:0] v_r;

  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int SH = QW - 1 - k;
    logic [NW-1:0] np;
    logic [DW-1:0] dp;
    logic [QW-1:0] qp;
    logic [WW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign np = num_i;
      assign dp = den_i;
      assign qp = '0;
    end else begin : g_next
      assign np = n_r[k-1];
      assign dp = d_r[k-1];
      assign qp = q_r[k-1];
    end

    assign trial = WW'(dp) << SH;
    assign ge    = WW'(np) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= ge ? NW'(WW'(np) - trial) : np;
        d_r[k] <= dp;
        q_r[k] <= {qp[QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  assign out_valid = v_r[QW-1];
  assign quo_o     = q_r[QW-1];
  assign rem_o     = n_r[QW-1];

endmodule

`default_nettype wire

[rtl/core/prg_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// prg_sqrt_pipe
// Integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module prg_sqrt_pipe #(
  parameter int IW = 62
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [IW-1:0]   rad_i,
  output logic                 out_valid,
  output logic [IW/2-1:0]      root_o
);

  localparam int RW = IW / 2;
  localparam int MW = RW + 2;

  logic [IW-1:0] x_r [RW];
  logic [MW-1:0] m_r [RW];
  logic [RW-1:0] r_r [RW];
  logic [RW-1:0] v_r;

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [IW-1:0] xp;
    logic [MW-1:0] mp;
    logic [RW-1:0] rp;
    logic [MW+1:0] sh;
    logic [MW+1:0] tr;

    if (k == 0) begin : g_first
      assign xp = rad_i;
      assign mp = '0;
      assign rp = '0;
    end else begin : g_next
      assign xp = x_r[k-1];
      assign mp = m_r[k-1];
      assign rp = r_r[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign sh = {mp, xp[IW-1:IW-2]};
    assign tr = (MW+2)'({rp, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k] <= xp << 2;
        if (sh >= tr) begin
          m_r[k] <= MW'(sh - tr);
          r_r[k] <= {rp[RW-2:0], 1'b1};
        end else begin
          m_r[k] <= MW'(sh);
          r_r[k] <= {rp[RW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[RW-2:0], in_valid};
    end
  end

  assign out_valid = v_r[RW-1];
  assign root_o    = r_r[RW-1];

endmodule

`default_nettype wire

[rtl/core/perspective_ray_generator.sv]
// ----------------------------------------------------------------------------
// perspective_ray_generator
// Pinhole camera: pixel index to column, row and rotated unit ray direction.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      pixel_index
//  out_ch    out  valid/ready      pixel_col, pixel_row, dir_x/y/z
//  cfg_*     in   cfg_we only      cfg_idx selects register, cfg_data value
//
//  one request per cycle while the pipeline advances; the pipeline contains the
//  24-stage index divider, the 31-stage square root and the
//  DIR_FRAC_BITS+1 stage normalising dividers.
//  the whole pipeline advances when the output register is empty or taken;
//  while it holds, every stage holds and in_ch.ready is low.
//  synchronous reset clears valid bits and loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_ray_generator #(
  parameter int MAX_SIDE      = 4096,
  parameter int DIR_FRAC_BITS = 15
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  prg_stream_if.sink                        in_ch,
  prg_stream_if.source                      out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [prg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [prg_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int F    = DIR_FRAC_BITS;
  localparam int PW   = 51;          // sx/sy times scale
  localparam int MGW  = 50;
  localparam int NMW  = 30;
  localparam int SQW  = 62;
  localparam int RTW  = SQW / 2;
  localparam int DNW  = RTW + F;
  localparam int QTW  = F + 1;
  localparam int VW   = F + 2;
  localparam int DDW  = VW + 17;
  localparam int TW   = VW + 3;
  localparam int EW   = TW + 18;
  localparam int QRW  = EW + 8;
  localparam int IDXW = prg_pkg::IDX_W;
  localparam int CW   = prg_pkg::COORD_W;

  // configuration
  logic [prg_pkg::SIDE_REG_W-1:0]         width_r, height_r;
  logic [prg_pkg::SCALE_W-1:0]            scale_r;
  logic signed [prg_pkg::QUAT_W-1:0]      qw_r, qx_r, qy_r, qz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= prg_pkg::RST_WIDTH;
      height_r <= prg_pkg::RST_HEIGHT;
      scale_r  <= prg_pkg::RST_SCALE;
      qw_r     <= prg_pkg::RST_QW;
      qx_r     <= '0;
      qy_r     <= '0;
      qz_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        prg_pkg::CFG_SCREEN_WIDTH:  width_r  <= cfg_data[prg_pkg::SIDE_REG_W-1:0];
        prg_pkg::CFG_SCREEN_HEIGHT: height_r <= cfg_data[prg_pkg::SIDE_REG_W-1:0];
        prg_pkg::CFG_PIXEL_SCALE:   scale_r  <= cfg_data[prg_pkg::SCALE_W-1:0];
        prg_pkg::CFG_ROTATION_W:    qw_r     <= cfg_data[prg_pkg::QUAT_W-1:0];
        prg_pkg::CFG_ROTATION_X:    qx_r     <= cfg_data[prg_pkg::QUAT_W-1:0];
        prg_pkg::CFG_ROTATION_Y:    qy_r     <= cfg_data[prg_pkg::QUAT_W-1:0];
        prg_pkg::CFG_ROTATION_Z:    qz_r     <= cfg_data[prg_pkg::QUAT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] w_eff, h_eff;

  always_comb begin
    if (width_r == '0) begin
      w_eff = SW'(1);
    end else if (32'(width_r) > 32'(MAX_SIDE)) begin
      w_eff = SW'(MAX_SIDE);
    end else begin
      w_eff = SW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = SW'(1);
    end else if (32'(height_r) > 32'(MAX_SIDE)) begin
      h_eff = SW'(MAX_SIDE);
    end else begin
      h_eff = SW'(height_r);
    end
  end

  logic adv;
  logic out_v_r;
  prg_pkg::out_payload_t out_d_r;

  assign adv          = !out_v_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  // index split
  logic            d0_v;
  logic [IDXW-1:0] row_q, col_rem;

  prg_div_pipe #(.NW(IDXW), .DW(SW), .QW(IDXW)) u_idx_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_ch.valid),
    .num_i     (in_ch.data.pixel_index),
    .den_i     (w_eff),
    .out_valid (d0_v),
    .quo_o     (row_q),
    .rem_o     (col_rem)
  );

  // centre offsets and scaling
  logic signed [25:0]   sx, sy;
  logic                 mv_r;
  logic signed [PW-1:0] a_r, b_r;
  logic [CW-1:0]        col_m_r, row_m_r;

  assign sx = $signed({2'b00, col_rem}) - $signed(26'(w_eff >> 1));
  assign sy = $signed({2'b00, row_q}) - $signed(26'(h_eff >> 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r     <= sx * $signed({1'b0, scale_r});
      b_r     <= sy * $signed({1'b0, scale_r});
      col_m_r <= col_rem[CW-1:0];
      row_m_r <= row_q[CW-1:0];
    end
  end

  // magnitudes and normalising shift
  localparam logic [MGW-1:0] C_MAG = MGW'(1) << 24;

  logic [MGW-1:0] ma, mb, mmax;
  logic [5:0]     hb;
  logic [4:0]     sh_amt;
  logic           n1v_r;
  logic [MGW-1:0] ma_r, mb_r;
  logic           sa_r, sb_r;
  logic [4:0]     sh_r;
  logic [CW-1:0]  col_n1_r, row_n1_r;

  always_comb begin
    ma = MGW'(a_r[PW-1] ? -a_r : a_r);
    mb = MGW'(b_r[PW-1] ? -b_r : b_r);
    mmax = (ma > mb) ? ma : mb;
    if (C_MAG > mmax) begin
      mmax = C_MAG;
    end
    hb = '0;
    for (int i = 0; i < MGW; i++) begin
      if (mmax[i]) begin
        hb = 6'(i);
      end
    end
    sh_amt = (hb > 6'd29) ? 5'(hb - 6'd29) : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma_r     <= ma;
      mb_r     <= mb;
      sa_r     <= a_r[PW-1];
      sb_r     <= b_r[PW-1];
      sh_r     <= sh_amt;
      col_n1_r <= col_m_r;
      row_n1_r <= row_m_r;
    end
  end

  logic           n2v_r;
  logic [NMW-1:0] mg_n2_r [3];
  logic           sa_n2_r, sb_n2_r;
  logic [CW-1:0]  col_n2_r, row_n2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mg_n2_r[0] <= NMW'(ma_r >> sh_r);
      mg_n2_r[1] <= NMW'(mb_r >> sh_r);
      mg_n2_r[2] <= NMW'(C_MAG >> sh_r);
      sa_n2_r    <= sa_r;
      sb_n2_r    <= sb_r;
      col_n2_r   <= col_n1_r;
      row_n2_r   <= row_n1_r;
    end
  end

  // squares, then their sum
  typedef struct packed {
    logic [NMW-1:0] mg0;
    logic [NMW-1:0] mg1;
    logic [NMW-1:0] mg2;
    logic           sa;
    logic           sb;
    logic [CW-1:0]  col;
    logic [CW-1:0]  row;
  } norm_side_t;

  typedef struct packed {
    logic          sa;
    logic          sb;
    logic [CW-1:0] col;
    logic [CW-1:0] row;
  } div_side_t;

  logic               qv_r;
  logic [2*NMW-1:0]   sq_r [3];
  norm_side_t         side_q_r;
  logic               sv_r;
  logic [SQW-1:0]     sum_r;
  norm_side_t         side_s_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= mg_n2_r[i] * mg_n2_r[i];
      end
      side_q_r <= '{mg0: mg_n2_r[0], mg1: mg_n2_r[1], mg2: mg_n2_r[2],
                    sa: sa_n2_r, sb: sb_n2_r, col: col_n2_r, row: row_n2_r};
      sum_r    <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
      side_s_r <= side_q_r;
    end
  end

  // square root with side data alongside
  logic           rt_v;
  logic [RTW-1:0] root;
  norm_side_t     side_rt_r [RTW];

  prg_sqrt_pipe #(.IW(SQW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sv_r),
    .rad_i     (sum_r),
    .out_valid (rt_v),
    .root_o    (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_rt_r[0] <= side_s_r;
      for (int k = 1; k < RTW; k++) begin
        side_rt_r[k] <= side_rt_r[k-1];
      end
    end
  end

  // per-axis normalising division, rounded to nearest
  logic [RTW-1:0] nn;
  logic [DNW-1:0] num [3];
  logic [NMW-1:0] mg_rt [3];
  logic [2:0]     dv_v;
  logic [QTW-1:0] quo [3];
  div_side_t      side_dv_r [QTW];

  assign nn       = (root == '0) ? RTW'(1) : root;
  assign mg_rt[0] = side_rt_r[RTW-1].mg0;
  assign mg_rt[1] = side_rt_r[RTW-1].mg1;
  assign mg_rt[2] = side_rt_r[RTW-1].mg2;

  for (genvar j = 0; j < 3; j++) begin : g_ndiv
    assign num[j] = (DNW'(mg_rt[j]) << F) + DNW'(nn >> 1);

    prg_div_pipe #(.NW(DNW), .DW(RTW), .QW(QTW)) u_ndiv (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (rt_v),
      .num_i     (num[j]),
      .den_i     (nn),
      .out_valid (dv_v[j]),
      .quo_o     (quo[j]),
      .rem_o     ()
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dv_r[0] <= '{sa: side_rt_r[RTW-1].sa, sb: side_rt_r[RTW-1].sb,
                        col: side_rt_r[RTW-1].col, row: side_rt_r[RTW-1].row};
      for (int k = 1; k < QTW; k++) begin
        side_dv_r[k] <= side_dv_r[k-1];
      end
    end
  end

  // signed unit vector
  logic                 vv_r;
  logic signed [VW-1:0] v_r [3];
  logic [CW-1:0]        col_v_r, row_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r[0]  <= side_dv_r[QTW-1].sa ? -$signed({1'b0, quo[0]}) : $signed({1'b0, quo[0]});
      v_r[1]  <= side_dv_r[QTW-1].sb ? -$signed({1'b0, quo[1]}) : $signed({1'b0, quo[1]});
      v_r[2]  <= $signed({1'b0, quo[2]});
      col_v_r <= side_dv_r[QTW-1].col;
      row_v_r <= side_dv_r[QTW-1].row;
    end
  end

  // rotation, first cross product
  logic                  t1v_r;
  logic signed [DDW-1:0] d_r [3];
  logic signed [VW-1:0]  v_t1_r [3];
  logic [CW-1:0]         col_t1_r, row_t1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r[0]   <= qy_r * v_r[2] - qz_r * v_r[1];
      d_r[1]   <= qz_r * v_r[0] - qx_r * v_r[2];
      d_r[2]   <= qx_r * v_r[1] - qy_r * v_r[0];
      v_t1_r   <= v_r;
      col_t1_r <= col_v_r;
      row_t1_r <= row_v_r;
    end
  end

  // t = round(2 * u x v), then w*t + u x t
  logic signed [DDW:0]  d2 [3];
  logic signed [TW-1:0] t [3];
  logic                 t2v_r;
  logic signed [EW-1:0] e_r [3];
  logic signed [VW-1:0] v_t2_r [3];
  logic [CW-1:0]        col_t2_r, row_t2_r;

  for (genvar j = 0; j < 3; j++) begin : g_t
    logic signed [DDW:0] tr;
    assign d2[j] = {d_r[j], 1'b0};
    assign tr    = (d2[j] + 16384) >>> 15;
    assign t[j]  = tr[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r[0]   <= qw_r * t[0] + (qy_r * t[2] - qz_r * t[1]);
      e_r[1]   <= qw_r * t[1] + (qz_r * t[0] - qx_r * t[2]);
      e_r[2]   <= qw_r * t[2] + (qx_r * t[1] - qy_r * t[0]);
      v_t2_r   <= v_t1_r;
      col_t2_r <= col_t1_r;
      row_t2_r <= row_t1_r;
    end
  end

  // final sum, conversion to q1.15 and saturation
  localparam int DIR_W_C = prg_pkg::DIR_W;
  logic signed [DIR_W_C-1:0] dir [3];

  for (genvar j = 0; j < 3; j++) begin : g_out
    logic signed [EW-1:0]  re;
    logic signed [EW-1:0]  r;
    logic signed [QRW-1:0] rq;

    assign re = (e_r[j] + 16384) >>> 15;
    assign r  = EW'(v_t2_r[j]) + re;

    if (F > 15) begin : g_down
      localparam int RH = 1 << (F - 16);
      assign rq = (QRW'(r) + RH) >>> (F - 15);
    end else begin : g_up
      assign rq = QRW'(r) <<< (15 - F);
    end

    always_comb begin
      if (rq > 32767) begin
        dir[j] = 16'sh7fff;
      end else if (rq < -32768) begin
        dir[j] = -16'sh8000;
      end else begin
        dir[j] = rq[DIR_W_C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d_r.pixel_col <= col_t2_r;
      out_d_r.pixel_row <= row_t2_r;
      out_d_r.dir_x     <= dir[0];
      out_d_r.dir_y     <= dir[1];
      out_d_r.dir_z     <= dir[2];
    end
  end

  // valid bits of the local stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r    <= 1'b0;
      n1v_r   <= 1'b0;
      n2v_r   <= 1'b0;
      qv_r    <= 1'b0;
      sv_r    <= 1'b0;
      vv_r    <= 1'b0;
      t1v_r   <= 1'b0;
      t2v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      mv_r    <= d0_v;
      n1v_r   <= mv_r;
      n2v_r   <= n1v_r;
      qv_r    <= n2v_r;
      sv_r    <= qv_r;
      vv_r    <= &dv_v;
      t1v_r   <= vv_r;
      t2v_r   <= t1v_r;
      out_v_r <= t2v_r;
    end
  end

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Pinhole ray generator check: a few screen and rotation settings, each
// followed by pixel requests. Every result is compared with a fixed-point
// ray tracer held in the bench or with a typed value, under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // unused register index, writes to it must be ignored
  localparam logic [prg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  // camera setting with enough requests to fill the pipeline under hold-off
  localparam int LONG_PHASE = 5;

  typedef struct {
    logic [prg_pkg::IDX_W-1:0] pixel_index;
    bit                        typed;
    prg_pkg::out_payload_t     result;
  } pixel_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [prg_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [prg_pkg::CFG_DATA_W-1:0] cfg_data;

  prg_stream_if #(.payload_t(prg_pkg::in_payload_t))  in_if ();
  prg_stream_if #(.payload_t(prg_pkg::out_payload_t)) out_if ();

  perspective_ray_generator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // bench copy of the camera registers
  logic [prg_pkg::SIDE_REG_W-1:0] cam_width;
  logic [prg_pkg::SIDE_REG_W-1:0] cam_height;
  logic [prg_pkg::SCALE_W-1:0]    cam_scale;
  logic signed [15:0]             quat_w, quat_x, quat_y, quat_z;

  prg_pkg::out_payload_t rays_due[$];
  int                    mismatches;
  int                    rays_seen;
  int                    requests_sent;
  int                    phases_run;
  pixel_row_t            directed[];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // round half up, floor division by 2^15
  function automatic longint round_q15(longint x);
    return (x + 64'sd16384) >>> 15;
  endfunction

  function automatic longint clamp_side(longint v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic prg_pkg::out_payload_t trace_ray(logic [prg_pkg::IDX_W-1:0] idx);
    longint                w, h, col, row, qw, qx, qy, qz;
    longint                comp[3], v[3], t[3], r[3];
    longint unsigned       mag[3], m, sum, n, q;
    int                    s;
    prg_pkg::out_payload_t res;
    w = clamp_side(cam_width);
    h = clamp_side(cam_height);
    col = longint'(idx) % w;
    row = longint'(idx) / w;
    comp[0] = (col - w / 2) * longint'(cam_scale);
    comp[1] = (row - h / 2) * longint'(cam_scale);
    comp[2] = 64'sd1 << 24;
    for (int i = 0; i < 3; i++) mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) mag[i] >>= s;
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    n = int_sqrt(sum);
    if (n == 0) n = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 15) + n / 2) / n;
      v[i] = comp[i] < 0 ? -longint'(q) : longint'(q);
    end
    qw = quat_w; qx = quat_x; qy = quat_y; qz = quat_z;
    t[0] = round_q15(2 * (qy * v[2] - qz * v[1]));
    t[1] = round_q15(2 * (qz * v[0] - qx * v[2]));
    t[2] = round_q15(2 * (qx * v[1] - qy * v[0]));
    r[0] = v[0] + round_q15(qw * t[0] + (qy * t[2] - qz * t[1]));
    r[1] = v[1] + round_q15(qw * t[1] + (qz * t[0] - qx * t[2]));
    r[2] = v[2] + round_q15(qw * t[2] + (qx * t[1] - qy * t[0]));
    for (int i = 0; i < 3; i++) begin
      if (r[i] > 32767) r[i] = 32767;
      if (r[i] < -32768) r[i] = -32768;
    end
    res.pixel_col = col[prg_pkg::COORD_W-1:0];
    res.pixel_row = row[prg_pkg::COORD_W-1:0];
    res.dir_x = r[0][15:0];
    res.dir_y = r[1][15:0];
    res.dir_z = r[2][15:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // output side: compare each accepted ray with the oldest one due
  always @(posedge clk) begin
    prg_pkg::out_payload_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      rays_seen++;
      if (rays_due.size() == 0) begin
        $display("[%0t] ray returned with no request outstanding", $realtime);
        mismatches++;
      end else begin
        want = rays_due.pop_front();
        if (got.pixel_col !== want.pixel_col)
          report_mismatch("pixel_col", got.pixel_col, want.pixel_col);
        if (got.pixel_row !== want.pixel_row)
          report_mismatch("pixel_row", got.pixel_row, want.pixel_row);
        if (got.dir_x !== want.dir_x) report_mismatch("dir_x", got.dir_x, want.dir_x);
        if (got.dir_y !== want.dir_y) report_mismatch("dir_y", got.dir_y, want.dir_y);
        if (got.dir_z !== want.dir_z) report_mismatch("dir_z", got.dir_z, want.dir_z);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to fill the pipeline
  initial begin
    bit held;
    held = 0;
    out_if.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && phases_run == LONG_PHASE + 1) begin
        held = 1;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if ($urandom_range(99) < 20) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(99) < 85 ? $urandom_range(1, 3) : $urandom_range(10, 30))
          @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic cfg_write(logic [prg_pkg::CFG_IDX_W-1:0] idx,
                           logic [prg_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      prg_pkg::CFG_SCREEN_WIDTH:  cam_width = val[prg_pkg::SIDE_REG_W-1:0];
      prg_pkg::CFG_SCREEN_HEIGHT: cam_height = val[prg_pkg::SIDE_REG_W-1:0];
      prg_pkg::CFG_PIXEL_SCALE:   cam_scale = val[prg_pkg::SCALE_W-1:0];
      prg_pkg::CFG_ROTATION_W:    quat_w = val[15:0];
      prg_pkg::CFG_ROTATION_X:    quat_x = val[15:0];
      prg_pkg::CFG_ROTATION_Y:    quat_y = val[15:0];
      prg_pkg::CFG_ROTATION_Z:    quat_z = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(int w, int h, int scale, int qw, int qx, int qy, int qz);
    logic [31:0] junk;
    junk = $urandom;
    cfg_write(prg_pkg::CFG_SCREEN_WIDTH, w[prg_pkg::CFG_DATA_W-1:0]);
    cfg_write(prg_pkg::CFG_SCREEN_HEIGHT, h[prg_pkg::CFG_DATA_W-1:0]);
    cfg_write(prg_pkg::CFG_PIXEL_SCALE, scale[prg_pkg::CFG_DATA_W-1:0]);
    cfg_write(prg_pkg::CFG_ROTATION_W, qw[prg_pkg::CFG_DATA_W-1:0]);
    cfg_write(prg_pkg::CFG_ROTATION_X, qx[prg_pkg::CFG_DATA_W-1:0]);
    cfg_write(prg_pkg::CFG_ROTATION_Y, qy[prg_pkg::CFG_DATA_W-1:0]);
    cfg_write(prg_pkg::CFG_ROTATION_Z, qz[prg_pkg::CFG_DATA_W-1:0]);
    cfg_write(CFG_SPARE, junk[prg_pkg::CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic [prg_pkg::IDX_W-1:0] idx, bit typed,
                            prg_pkg::out_payload_t result);
    in_if.valid <= 1'b1;
    in_if.data.pixel_index <= idx;
    do @(posedge clk); while (!in_if.ready);
    rays_due.push_back(typed ? result : trace_ray(idx));
    requests_sent++;
    if ($urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(99) < 85 ? $urandom_range(1, 3) : $urandom_range(10, 40))
        @(posedge clk);
    end
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (rays_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [prg_pkg::IDX_W-1:0] random_pixel;
    longint      area;
    logic [31:0] pick;
    area = clamp_side(cam_width) * clamp_side(cam_height);
    if ($urandom_range(99) < 15) pick = $urandom;
    else pick = $urandom_range(32'(area - 1), 0);
    return pick[prg_pkg::IDX_W-1:0];
  endfunction

  initial begin
    prg_pkg::out_payload_t none, centre;
    none = '0;
    centre = '{pixel_col: 320, pixel_row: 240, dir_x: 0, dir_y: 0, dir_z: 32767};
    mismatches = 0; rays_seen = 0; requests_sent = 0; phases_run = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0; cfg_idx <= '0; cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cam_width = prg_pkg::RST_WIDTH; cam_height = prg_pkg::RST_HEIGHT;
    cam_scale = prg_pkg::RST_SCALE;
    quat_w = prg_pkg::RST_QW; quat_x = 0; quat_y = 0; quat_z = 0;
    directed = '{
      '{24'd0,        0, none},
      '{24'd153920,   1, centre},    // screen centre straight down the axis
      '{24'hFFFFFF,   0, none},
      '{24'd639,      0, none},
      '{24'd640,      0, none},
      '{24'd307199,   0, none},      // last pixel on screen
      '{24'd307200,   0, none},      // just past the screen
      '{24'd2621439,  0, none},      // last row that fits in the 12-bit field
      '{24'hAAAAAA,   0, none},
      '{24'h555555,   0, none},
      '{24'd1,        0, none},
      '{24'd153600,   0, none},
      '{24'd154239,   0, none}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_pixel(directed[i].pixel_index, directed[i].typed, directed[i].result);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_camera(1, 1, 24'hFFFFFF, -32768, 0, 0, 0);
        1: set_camera(4096, 4096, 0, 32767, 32767, -32768, 32767);
        2: set_camera(0, 8191, $urandom, $urandom, $urandom, $urandom, $urandom);
        3: set_camera(8191, 0, 24'hFFFFFF, 0, -32768, -32768, -32768);
        4: set_camera(4096, 1, 24'hFFFFFF, 23170, 0, 23170, 0);
        default: set_camera($urandom_range(1, 4096), $urandom_range(1, 4096),
                            $urandom_range(99) < 70 ? $urandom_range(200000, 0) : $urandom,
                            $urandom, $urandom, $urandom, $urandom);
      endcase
      phases_run++;
      for (int k = 0; k < ((ph == LONG_PHASE) ? 120 : 45); k++)
        send_pixel(random_pixel(), 0, none);
      drain();
    end

    $display("%0d pixel requests over %0d camera settings, %0d rays checked",
             requests_sent, phases_run + 1, rays_seen);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/core/prg_pkg.sv
rtl/core/prg_stream_if.sv
rtl/core/prg_div_pipe.sv
rtl/core/prg_sqrt_pipe.sv
rtl/core/perspective_ray_generator.sv
verif/testbench.sv
